### src/vcs_pkg.sv
// Shared types, register codes and constants of the velocity command smoother.
`default_nettype none
package vcs_pkg;

  localparam int DEF_VALUE_WIDTH = 16;
  localparam int DT_W = 16;
  localparam int PADDR_W = 5;
  localparam int PDATA_W = 32;
  localparam int REG_IDX_W = 3;

  localparam logic [REG_IDX_W-1:0] REG_LIMIT_ABS     = 3'd0;
  localparam logic [REG_IDX_W-1:0] REG_DEADZONE      = 3'd1;
  localparam logic [REG_IDX_W-1:0] REG_LOWPASS_ALPHA = 3'd2;
  localparam logic [REG_IDX_W-1:0] REG_RATE_MODE     = 3'd3;
  localparam logic [REG_IDX_W-1:0] REG_ACCEL_LIMIT   = 3'd4;
  localparam logic [REG_IDX_W-1:0] REG_STEP_BOUND    = 3'd5;
  localparam logic [REG_IDX_W-1:0] REG_STEP_ADD      = 3'd6;

  localparam logic [14:0] RST_LIMIT_ABS     = 15'd4096;
  localparam logic [14:0] RST_DEADZONE      = 15'd0;
  localparam logic [15:0] RST_LOWPASS_ALPHA = 16'd0;
  localparam logic        RST_RATE_MODE     = 1'b1;
  localparam logic [14:0] RST_ACCEL_LIMIT   = 15'd4096;
  localparam logic [14:0] RST_STEP_BOUND    = 15'd0;
  localparam logic [14:0] RST_STEP_ADD      = 15'd0;

  // 0.8 and 0.2 as Q0.16 weights, summing to one
  localparam logic signed [16:0] W_0P8 = 17'sd52429;
  localparam logic signed [16:0] W_0P2 = 17'sd13107;

  typedef struct packed {
    logic [14:0] limit_abs;
    logic [14:0] deadzone;
    logic [15:0] lowpass_alpha;
    logic        rate_mode;
    logic [14:0] accel_limit;
    logic [14:0] step_bound;
    logic [14:0] step_add;
  } cfg_t;

  typedef enum logic [1:0] {
    MUL_LP  = 2'd0,
    MUL_ACC = 2'd1,
    MUL_W8  = 2'd2,
    MUL_W2  = 2'd3
  } mul_sel_t;

  typedef enum logic [1:0] {
    SRC_RATE  = 2'd0,
    SRC_STEP  = 2'd1,
    SRC_BLEND = 2'd2
  } cmd_src_t;

  typedef struct packed {
    logic     capture;
    logic     load_ref;
    logic     mul_en;
    mul_sel_t mul_sel;
    logic     acc_en;
    logic     upd_filt;
    logic     upd_cmd;
    cmd_src_t cmd_src;
    logic     load_out;
  } dp_cmd_t;

  typedef struct packed {
    logic kind;
    logic dt_zero;
    logic rate_mode;
    logic in_band;
  } dp_stat_t;

endpackage
`default_nettype wire

### src/vcs_regs.sv
// Configuration register file behind the APB-style port.
`default_nettype none
module vcs_regs (
  input  logic                         clk,
  input  logic                         rst,
  input  logic                         psel,
  input  logic                         penable,
  input  logic                         pwrite,
  input  logic [vcs_pkg::PADDR_W-1:0]  paddr,
  input  logic [vcs_pkg::PDATA_W-1:0]  pwdata,
  output logic [vcs_pkg::PDATA_W-1:0]  prdata,
  output logic                         pready,
  output vcs_pkg::cfg_t                cfg
);
  import vcs_pkg::*;

  logic [REG_IDX_W-1:0] idx;
  logic                 wr;

  assign idx    = paddr[PADDR_W-1:2];
  assign wr     = psel & penable & pwrite & pready;
  assign pready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      cfg.limit_abs     <= RST_LIMIT_ABS;
      cfg.deadzone      <= RST_DEADZONE;
      cfg.lowpass_alpha <= RST_LOWPASS_ALPHA;
      cfg.rate_mode     <= RST_RATE_MODE;
      cfg.accel_limit   <= RST_ACCEL_LIMIT;
      cfg.step_bound    <= RST_STEP_BOUND;
      cfg.step_add      <= RST_STEP_ADD;
    end else if (wr) begin
      unique case (idx)
        REG_LIMIT_ABS:     cfg.limit_abs     <= pwdata[14:0];
        REG_DEADZONE:      cfg.deadzone      <= pwdata[14:0];
        REG_LOWPASS_ALPHA: cfg.lowpass_alpha <= pwdata[15:0];
        REG_RATE_MODE:     cfg.rate_mode     <= pwdata[0];
        REG_ACCEL_LIMIT:   cfg.accel_limit   <= pwdata[14:0];
        REG_STEP_BOUND:    cfg.step_bound    <= pwdata[14:0];
        REG_STEP_ADD:      cfg.step_add      <= pwdata[14:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    unique case (idx)
      REG_LIMIT_ABS:     prdata = PDATA_W'(cfg.limit_abs);
      REG_DEADZONE:      prdata = PDATA_W'(cfg.deadzone);
      REG_LOWPASS_ALPHA: prdata = PDATA_W'(cfg.lowpass_alpha);
      REG_RATE_MODE:     prdata = PDATA_W'(cfg.rate_mode);
      REG_ACCEL_LIMIT:   prdata = PDATA_W'(cfg.accel_limit);
      REG_STEP_BOUND:    prdata = PDATA_W'(cfg.step_bound);
      REG_STEP_ADD:      prdata = PDATA_W'(cfg.step_add);
      default:           prdata = '0;
    endcase
  end

endmodule
`default_nettype wire

### src/vcs_datapath.sv
// Datapath: held state, shared multiplier, rounding, saturation and limiting.
`default_nettype none
module vcs_datapath #(
  parameter int VALUE_WIDTH = vcs_pkg::DEF_VALUE_WIDTH
) (
  input  logic                          clk,
  input  logic                          rst,
  input  vcs_pkg::cfg_t                 cfg,
  input  vcs_pkg::dp_cmd_t              cmd,
  output vcs_pkg::dp_stat_t             stat,
  input  logic                          in_kind,
  input  logic signed [VALUE_WIDTH-1:0] in_ref,
  input  logic [vcs_pkg::DT_W-1:0]      in_dt,
  output logic signed [VALUE_WIDTH-1:0] out_cmd
);
  import vcs_pkg::*;

  localparam int VW = VALUE_WIDTH;
  localparam int EW = ((VW > 16) ? VW : 16) + 3;
  localparam int MB = ((VW + 1) > 17) ? (VW + 1) : 17;
  localparam int PW = 17 + MB;
  localparam logic signed [EW-1:0] VMAX_E = (EW'(1) <<< (VW - 1)) - EW'(1);
  localparam logic signed [EW-1:0] VMIN_E = -VMAX_E - EW'(1);
  localparam logic signed [PW:0]   HALF   = (PW + 1)'(32768);

  function automatic logic signed [VW-1:0] sat(input logic signed [EW-1:0] x);
    logic signed [EW-1:0] y;
    y = (x > VMAX_E) ? VMAX_E : ((x < VMIN_E) ? VMIN_E : x);
    return y[VW-1:0];
  endfunction

  function automatic logic signed [VW-1:0] clamp_lim(input logic signed [EW-1:0] x,
                                                    input logic signed [EW-1:0] lim);
    logic signed [EW-1:0] y;
    y = (x > lim) ? lim : ((x < -lim) ? -lim : x);
    return y[VW-1:0];
  endfunction

  function automatic logic signed [EW-1:0] rnd16(input logic signed [PW:0] x);
    logic signed [PW:0] t;
    t = (x + HALF) >>> 16;
    return t[EW-1:0];
  endfunction

  logic signed [VW-1:0] held;
  logic signed [VW-1:0] filt;
  logic signed [VW-1:0] cmdv;
  logic [DT_W-1:0]      dt_r;
  logic signed [PW-1:0] prod;
  logic signed [PW-1:0] acc;

  logic signed [EW-1:0] lim_e, dz_e, bnd_e, add_e;
  logic signed [EW-1:0] held_e, mag_e, rz_e, filt_e, c_e, diff_e;
  logic signed [EW-1:0] ms_e, d_e, dcl_e, step_e;
  logic signed [VW-1:0] rz;
  logic signed [VW-1:0] ref_clamped;
  logic signed [VW-1:0] filt_next;
  logic signed [VW-1:0] cmd_next;
  logic signed [16:0]   ma;
  logic signed [MB-1:0] mb;
  logic signed [PW:0]   blend;
  logic                 above, below;

  always_comb begin
    lim_e  = EW'(cfg.limit_abs);
    if (lim_e > VMAX_E) begin
      lim_e = VMAX_E;
    end
    dz_e   = EW'(cfg.deadzone);
    bnd_e  = EW'(cfg.step_bound);
    add_e  = EW'(cfg.step_add);

    ref_clamped = clamp_lim(EW'(in_ref), lim_e);

    held_e = EW'(held);
    mag_e  = (held_e < 0) ? -held_e : held_e;
    rz     = (mag_e <= dz_e) ? '0 : held;
    rz_e   = EW'(rz);
    filt_e = EW'(filt);
    c_e    = EW'(cmdv);
    diff_e = rz_e - filt_e;

    unique case (cmd.mul_sel)
      MUL_LP:  begin
        ma = 17'({1'b0, cfg.lowpass_alpha});
        mb = diff_e[MB-1:0];
      end
      MUL_ACC: begin
        ma = 17'({2'b00, cfg.accel_limit});
        mb = MB'({1'b0, dt_r});
      end
      MUL_W8:  begin
        ma = W_0P8;
        mb = MB'(cmdv);
      end
      MUL_W2:  begin
        ma = W_0P2;
        mb = MB'(filt);
      end
      default: begin
        ma = '0;
        mb = '0;
      end
    endcase

    if (cfg.lowpass_alpha == '0) begin
      filt_next = rz;
    end else begin
      filt_next = sat(filt_e + rnd16((PW + 1)'(prod)));
    end

    above = (c_e + bnd_e) < filt_e;
    below = (c_e - bnd_e) > filt_e;

    ms_e  = rnd16((PW + 1)'(prod));
    d_e   = filt_e - c_e;
    dcl_e = (d_e > ms_e) ? ms_e : ((d_e < -ms_e) ? -ms_e : d_e);

    step_e = above ? (c_e + add_e) : (c_e - add_e);
    blend  = (PW + 1)'(acc) + (PW + 1)'(prod);

    unique case (cmd.cmd_src)
      SRC_RATE:  cmd_next = clamp_lim(EW'(sat(c_e + dcl_e)), lim_e);
      SRC_STEP:  cmd_next = clamp_lim(EW'(sat(step_e)), lim_e);
      SRC_BLEND: cmd_next = clamp_lim(EW'(sat(rnd16(blend))), lim_e);
      default:   cmd_next = cmdv;
    endcase
  end

  assign stat.kind      = in_kind;
  assign stat.dt_zero   = (in_dt == '0);
  assign stat.rate_mode = cfg.rate_mode;
  assign stat.in_band   = !(above || below);

  always_ff @(posedge clk) begin
    if (rst) begin
      held <= '0;
      filt <= '0;
      cmdv <= '0;
    end else begin
      if (cmd.load_ref) begin
        held <= ref_clamped;
      end
      if (cmd.upd_filt) begin
        filt <= filt_next;
      end
      if (cmd.upd_cmd) begin
        cmdv <= cmd_next;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.capture) begin
      dt_r <= in_dt;
    end
    if (cmd.mul_en) begin
      prod <= ma * mb;
    end
    if (cmd.acc_en) begin
      acc <= prod;
    end
    if (cmd.load_out) begin
      out_cmd <= cmdv;
    end
  end

endmodule
`default_nettype wire

### src/vcs_ctrl.sv
// Control state machine: sequences the stages of one word and the output handshake.
`default_nettype none
module vcs_ctrl (
  input  logic               clk,
  input  logic               rst,
  input  logic               s_tvalid,
  output logic               s_tready,
  output logic               m_tvalid,
  input  logic               m_tready,
  input  vcs_pkg::dp_stat_t  stat,
  output vcs_pkg::dp_cmd_t   cmd
);
  import vcs_pkg::*;

  typedef enum logic [8:0] {
    S_IDLE = 9'b000000001,
    S_LPM  = 9'b000000010,
    S_LPU  = 9'b000000100,
    S_RM   = 9'b000001000,
    S_RU   = 9'b000010000,
    S_ST   = 9'b000100000,
    S_SM   = 9'b001000000,
    S_SBL  = 9'b010000000,
    S_DONE = 9'b100000000
  } state_t;

  state_t state, state_next;
  logic   accept;
  logic   out_free;

  assign s_tready = (state == S_IDLE);
  assign accept   = s_tvalid & s_tready;
  assign out_free = !m_tvalid || m_tready;

  always_comb begin
    state_next  = state;
    cmd         = '0;
    cmd.mul_sel = MUL_LP;
    cmd.cmd_src = SRC_RATE;
    unique case (state)
      S_IDLE: begin
        if (accept) begin
          cmd.capture  = 1'b1;
          cmd.load_ref = !stat.kind;
          if (stat.kind) begin
            state_next = stat.dt_zero ? S_DONE : S_LPM;
          end
        end
      end
      S_LPM: begin
        cmd.mul_en  = 1'b1;
        cmd.mul_sel = MUL_LP;
        state_next  = S_LPU;
      end
      S_LPU: begin
        cmd.upd_filt = 1'b1;
        state_next   = stat.rate_mode ? S_RM : S_ST;
      end
      S_RM: begin
        cmd.mul_en  = 1'b1;
        cmd.mul_sel = MUL_ACC;
        state_next  = S_RU;
      end
      S_RU: begin
        cmd.upd_cmd = 1'b1;
        cmd.cmd_src = SRC_RATE;
        state_next  = S_DONE;
      end
      S_ST: begin
        cmd.mul_en  = 1'b1;
        cmd.mul_sel = MUL_W8;
        cmd.cmd_src = SRC_STEP;
        if (stat.in_band) begin
          state_next = S_SM;
        end else begin
          cmd.upd_cmd = 1'b1;
          state_next  = S_DONE;
        end
      end
      S_SM: begin
        cmd.acc_en  = 1'b1;
        cmd.mul_en  = 1'b1;
        cmd.mul_sel = MUL_W2;
        state_next  = S_SBL;
      end
      S_SBL: begin
        cmd.upd_cmd = 1'b1;
        cmd.cmd_src = SRC_BLEND;
        state_next  = S_DONE;
      end
      S_DONE: begin
        if (out_free) begin
          cmd.load_out = 1'b1;
          state_next   = S_IDLE;
        end
      end
      default: state_next = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state    <= S_IDLE;
      m_tvalid <= 1'b0;
    end else begin
      state <= state_next;
      if (cmd.load_out) begin
        m_tvalid <= 1'b1;
      end else if (m_tready) begin
        m_tvalid <= 1'b0;
      end
    end
  end

endmodule
`default_nettype wire

### src/velocity_command_smoother.sv
// Top level of the single-axis velocity command smoother.
// A set-reference word is taken, leaves the block ready and gives no result. A tick with
// dt of zero returns the current command. A tick with nonzero dt runs deadzone, low-pass,
// smoothing and limit as a sequence on one shared multiplier, 17 bits by VALUE_WIDTH+1 bits
// but at least 17, with a registered product: a low-pass multiply and filter update; in rate
// mode a rate-limit multiply and command update, in step mode a step update outside the
// band or a blend of two weighted products inside it. The result sits in an output
// register, so the block returns to accepting words as soon as that register is free;
// configuration writes are taken at any time and reads return the register value.
`default_nettype none
module velocity_command_smoother #(
  parameter int VALUE_WIDTH = vcs_pkg::DEF_VALUE_WIDTH,
  localparam int IN_W  = ((VALUE_WIDTH + vcs_pkg::DT_W + 7) / 8) * 8,
  localparam int OUT_W = ((VALUE_WIDTH + 7) / 8) * 8
) (
  input  logic                        clk,
  input  logic                        rst,
  input  logic                        s_tvalid,
  output logic                        s_tready,
  input  logic [IN_W-1:0]             s_tdata,  // reference, dt
  input  logic                        s_tuser,  // kind
  output logic                        m_tvalid,
  input  logic                        m_tready,
  output logic [OUT_W-1:0]            m_tdata,  // command
  input  logic                        psel,
  input  logic                        penable,
  input  logic                        pwrite,
  input  logic [vcs_pkg::PADDR_W-1:0] paddr,
  input  logic [vcs_pkg::PDATA_W-1:0] pwdata,
  output logic [vcs_pkg::PDATA_W-1:0] prdata,
  output logic                        pready
);
  import vcs_pkg::*;

  cfg_t                         cfg;
  dp_cmd_t                      cmd;
  dp_stat_t                     stat;
  logic signed [VALUE_WIDTH-1:0] in_ref;
  logic [DT_W-1:0]               in_dt;
  logic signed [VALUE_WIDTH-1:0] out_cmd;

  assign in_ref  = s_tdata[VALUE_WIDTH-1:0];
  assign in_dt   = s_tdata[VALUE_WIDTH+DT_W-1:VALUE_WIDTH];
  assign m_tdata = OUT_W'($unsigned(out_cmd));

  vcs_regs u_regs (
    .clk     (clk),
    .rst     (rst),
    .psel    (psel),
    .penable (penable),
    .pwrite  (pwrite),
    .paddr   (paddr),
    .pwdata  (pwdata),
    .prdata  (prdata),
    .pready  (pready),
    .cfg     (cfg)
  );

  vcs_ctrl u_ctrl (
    .clk      (clk),
    .rst      (rst),
    .s_tvalid (s_tvalid),
    .s_tready (s_tready),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .stat     (stat),
    .cmd      (cmd)
  );

  vcs_datapath #(
    .VALUE_WIDTH (VALUE_WIDTH)
  ) u_dp (
    .clk     (clk),
    .rst     (rst),
    .cfg     (cfg),
    .cmd     (cmd),
    .stat    (stat),
    .in_kind (s_tuser),
    .in_ref  (in_ref),
    .in_dt   (in_dt),
    .out_cmd (out_cmd)
  );

endmodule
`default_nettype wire

### src/vcs_checker.sv
// Port-level checker of the velocity command smoother and its bind.
`default_nettype none
module vcs_checker #(
  parameter int VALUE_WIDTH = vcs_pkg::DEF_VALUE_WIDTH,
  localparam int OUT_W = ((VALUE_WIDTH + 7) / 8) * 8
) (
  input logic             clk,
  input logic             rst,
  input logic             s_tvalid,
  input logic             s_tready,
  input logic             s_tuser,
  input logic             m_tvalid,
  input logic             m_tready,
  input logic [OUT_W-1:0] m_tdata
);
  localparam logic [VALUE_WIDTH-1:0] MOST_NEG = {1'b1, {(VALUE_WIDTH - 1){1'b0}}};

  a_reset_clears_out: assert property (@(posedge clk) rst |=> !m_tvalid)
    else $error("output valid after reset");

  a_out_hold: assert property (@(posedge clk) disable iff (rst)
    m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata))
    else $error("stalled output word changed");

  a_cmd_limited: assert property (@(posedge clk) disable iff (rst)
    m_tvalid |-> m_tdata[VALUE_WIDTH-1:0] != MOST_NEG)
    else $error("command outside symmetric limit");

  a_tick_busy: assert property (@(posedge clk) disable iff (rst)
    s_tvalid && s_tready && s_tuser |=> !s_tready)
    else $error("tick word did not occupy the block");

  a_setref_fast: assert property (@(posedge clk) disable iff (rst)
    s_tvalid && s_tready && !s_tuser |=> s_tready)
    else $error("set-reference word stalled the input");

endmodule

bind velocity_command_smoother vcs_checker #(
  .VALUE_WIDTH (VALUE_WIDTH)
) u_vcs_checker (.*);
`default_nettype wire
